[sv/cbz_pkg.sv]
// shared constants and register indexes for the cubic bezier evaluator
package cbz_pkg;

    // default coordinate and fraction widths
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    // configuration register file
    localparam int NUM_REGS     = 8;
    localparam int CFG_IDX_BITS = 4;
    localparam int REG_SEL_BITS = $clog2(NUM_REGS);

    // register indexes
    localparam logic [REG_SEL_BITS-1:0] REG_P0_X = 3'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_P0_Y = 3'd1;
    localparam logic [REG_SEL_BITS-1:0] REG_P1_X = 3'd2;
    localparam logic [REG_SEL_BITS-1:0] REG_P1_Y = 3'd3;
    localparam logic [REG_SEL_BITS-1:0] REG_P2_X = 3'd4;
    localparam logic [REG_SEL_BITS-1:0] REG_P2_Y = 3'd5;
    localparam logic [REG_SEL_BITS-1:0] REG_P3_X = 3'd6;
    localparam logic [REG_SEL_BITS-1:0] REG_P3_Y = 3'd7;

    // axis positions in per-axis arrays
    localparam int AX_X = 0;
    localparam int AX_Y = 1;

endpackage

[sv/cbz_lerp.sv]
// fixed-point linear interpolation a + round((b - a) * t), ties toward plus infinity
module cbz_lerp #(
    parameter int COORD_BITS = cbz_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = cbz_pkg::DEF_FRAC_BITS
) (
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    input  logic        [FRAC_BITS:0]    i_t,
    output logic signed [COORD_BITS-1:0] o_y
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = DW + FRAC_BITS + 2;
    localparam int SW = PW - FRAC_BITS;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic signed [DW-1:0]        w_diff;
    logic signed [FRAC_BITS+1:0] w_tt;
    logic signed [PW-1:0]        w_prod;
    logic signed [PW-1:0]        w_rnd;
    logic signed [SW-1:0]        w_step;
    logic signed [SW-1:0]        w_a_ext;
    logic signed [SW-1:0]        w_sum;

    // difference and scaled step
    assign w_diff  = {i_b[COORD_BITS-1], i_b} - {i_a[COORD_BITS-1], i_a};
    assign w_tt    = {1'b0, i_t};
    assign w_prod  = PW'(w_diff) * PW'(w_tt);
    assign w_rnd   = w_prod + HALF;

    // floor division by the fraction weight is an arithmetic shift
    assign w_step  = w_rnd[PW-1:FRAC_BITS];
    assign w_a_ext = {{(SW-COORD_BITS){i_a[COORD_BITS-1]}}, i_a};
    assign w_sum   = w_a_ext + w_step;

    // for t up to one the result lies between a and b, so truncation is exact
    assign o_y = w_sum[COORD_BITS-1:0];

endmodule

[sv/cubic_bezier_eval_split.sv]
// Cubic bezier point, tangent and split controls by a four-stage de Casteljau pipeline.
// A result strobes on o_valid once start is taken and the word has passed through stages 1 to 4 in order.
// Throughput: one word per cycle; busy is never raised.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) clears the stage valid bits and all control points to zero.
// Control points must only be written while no word is in flight.
module cubic_bezier_eval_split #(
    parameter int COORD_BITS = cbz_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = cbz_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [cbz_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [COORD_BITS-1:0]              i_cfg_data,
    // command side
    input  logic                               start,
    output logic                               busy,
    input  logic [FRAC_BITS:0]                 i_param_t,
    // result side
    output logic                               o_valid,
    output logic signed [COORD_BITS-1:0]       o_point_x,
    output logic signed [COORD_BITS-1:0]       o_point_y,
    output logic signed [COORD_BITS+2:0]       o_slope_x,
    output logic signed [COORD_BITS+2:0]       o_slope_y,
    output logic signed [COORD_BITS-1:0]       o_left_a_x,
    output logic signed [COORD_BITS-1:0]       o_left_a_y,
    output logic signed [COORD_BITS-1:0]       o_left_b_x,
    output logic signed [COORD_BITS-1:0]       o_left_b_y,
    output logic signed [COORD_BITS-1:0]       o_right_b_x,
    output logic signed [COORD_BITS-1:0]       o_right_b_y,
    output logic signed [COORD_BITS-1:0]       o_right_a_x,
    output logic signed [COORD_BITS-1:0]       o_right_a_y
);

    import cbz_pkg::*;

    localparam int SLW = COORD_BITS + 3;
    localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    // control point registers
    logic signed [COORD_BITS-1:0] r_p [NUM_REGS];

    // per-axis views of the control points
    logic signed [COORD_BITS-1:0] w_p0 [2];
    logic signed [COORD_BITS-1:0] w_p1 [2];
    logic signed [COORD_BITS-1:0] w_p2 [2];
    logic signed [COORD_BITS-1:0] w_p3 [2];

    // stage 1: clamped parameter
    logic                 r_v1;
    logic [FRAC_BITS:0]   r_t1;
    logic [FRAC_BITS:0]   n_t1;

    // stage 2: first level
    logic                          r_v2;
    logic [FRAC_BITS:0]            r_t2;
    logic signed [COORD_BITS-1:0]  n_q0 [2];
    logic signed [COORD_BITS-1:0]  n_q1 [2];
    logic signed [COORD_BITS-1:0]  n_q2 [2];
    logic signed [COORD_BITS-1:0]  r_q0_2 [2];
    logic signed [COORD_BITS-1:0]  r_q1_2 [2];
    logic signed [COORD_BITS-1:0]  r_q2_2 [2];

    // stage 3: second level
    logic                          r_v3;
    logic [FRAC_BITS:0]            r_t3;
    logic signed [COORD_BITS-1:0]  n_r0 [2];
    logic signed [COORD_BITS-1:0]  n_r1 [2];
    logic signed [COORD_BITS-1:0]  r_r0_3 [2];
    logic signed [COORD_BITS-1:0]  r_r1_3 [2];
    logic signed [COORD_BITS-1:0]  r_q0_3 [2];
    logic signed [COORD_BITS-1:0]  r_q2_3 [2];

    // stage 4: curve point, tangent and output words
    logic                          r_v4;
    logic signed [COORD_BITS-1:0]  n_s0 [2];
    logic signed [COORD_BITS:0]    w_dr [2];
    logic signed [SLW-1:0]         n_sl [2];
    logic signed [COORD_BITS-1:0]  r_s0_4 [2];
    logic signed [SLW-1:0]         r_sl_4 [2];
    logic signed [COORD_BITS-1:0]  r_q0_4 [2];
    logic signed [COORD_BITS-1:0]  r_r0_4 [2];
    logic signed [COORD_BITS-1:0]  r_r1_4 [2];
    logic signed [COORD_BITS-1:0]  r_q2_4 [2];

    // configuration writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_p[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_BITS'(NUM_REGS))) begin
            r_p[i_cfg_idx[REG_SEL_BITS-1:0]] <= i_cfg_data;
        end
    end

    assign w_p0[AX_X] = r_p[REG_P0_X];
    assign w_p0[AX_Y] = r_p[REG_P0_Y];
    assign w_p1[AX_X] = r_p[REG_P1_X];
    assign w_p1[AX_Y] = r_p[REG_P1_Y];
    assign w_p2[AX_X] = r_p[REG_P2_X];
    assign w_p2[AX_Y] = r_p[REG_P2_Y];
    assign w_p3[AX_X] = r_p[REG_P3_X];
    assign w_p3[AX_Y] = r_p[REG_P3_Y];

    // parameter clamp to one
    assign n_t1 = (i_param_t > T_ONE) ? T_ONE : i_param_t;

    // interpolation levels per axis
    for (genvar c = 0; c < 2; c++) begin : g_axis
        cbz_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_q0 (
            .i_a(w_p0[c]), .i_b(w_p1[c]), .i_t(r_t1), .o_y(n_q0[c])
        );
        cbz_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_q1 (
            .i_a(w_p1[c]), .i_b(w_p2[c]), .i_t(r_t1), .o_y(n_q1[c])
        );
        cbz_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_q2 (
            .i_a(w_p2[c]), .i_b(w_p3[c]), .i_t(r_t1), .o_y(n_q2[c])
        );
        cbz_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_r0 (
            .i_a(r_q0_2[c]), .i_b(r_q1_2[c]), .i_t(r_t2), .o_y(n_r0[c])
        );
        cbz_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_r1 (
            .i_a(r_q1_2[c]), .i_b(r_q2_2[c]), .i_t(r_t2), .o_y(n_r1[c])
        );
        cbz_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_s0 (
            .i_a(r_r0_3[c]), .i_b(r_r1_3[c]), .i_t(r_t3), .o_y(n_s0[c])
        );

        // tangent, three times the second-level difference
        assign w_dr[c] = {r_r1_3[c][COORD_BITS-1], r_r1_3[c]}
                       - {r_r0_3[c][COORD_BITS-1], r_r0_3[c]};
        assign n_sl[c] = {{2{w_dr[c][COORD_BITS]}}, w_dr[c]}
                       + {w_dr[c][COORD_BITS], w_dr[c], 1'b0};
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_t1 <= n_t1;
        r_t2 <= r_t1;
        r_t3 <= r_t2;
        for (int c = 0; c < 2; c++) begin
            r_q0_2[c] <= n_q0[c];
            r_q1_2[c] <= n_q1[c];
            r_q2_2[c] <= n_q2[c];
            r_r0_3[c] <= n_r0[c];
            r_r1_3[c] <= n_r1[c];
            r_q0_3[c] <= r_q0_2[c];
            r_q2_3[c] <= r_q2_2[c];
            r_s0_4[c] <= n_s0[c];
            r_sl_4[c] <= n_sl[c];
            r_q0_4[c] <= r_q0_3[c];
            r_r0_4[c] <= r_r0_3[c];
            r_r1_4[c] <= r_r1_3[c];
            r_q2_4[c] <= r_q2_3[c];
        end
    end

    // result ports
    assign busy        = 1'b0;
    assign o_valid     = r_v4;
    assign o_point_x   = r_s0_4[AX_X];
    assign o_point_y   = r_s0_4[AX_Y];
    assign o_slope_x   = r_sl_4[AX_X];
    assign o_slope_y   = r_sl_4[AX_Y];
    assign o_left_a_x  = r_q0_4[AX_X];
    assign o_left_a_y  = r_q0_4[AX_Y];
    assign o_left_b_x  = r_r0_4[AX_X];
    assign o_left_b_y  = r_r0_4[AX_Y];
    assign o_right_b_x = r_r1_4[AX_X];
    assign o_right_b_y = r_r1_4[AX_Y];
    assign o_right_a_x = r_q2_4[AX_X];
    assign o_right_a_y = r_q2_4[AX_Y];

`ifndef SYNTHESIS
    // a result only follows a command that was taken and carried through every stage
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without matching command");

    // the curve point lies between the second-level points on x
    a_point_x_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_point_x >= o_left_b_x && o_point_x <= o_right_b_x)
                  || (o_point_x <= o_left_b_x && o_point_x >= o_right_b_x)))
        else $error("curve point x outside second-level span");

    // the curve point lies between the second-level points on y
    a_point_y_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_point_y >= o_left_b_y && o_point_y <= o_right_b_y)
                  || (o_point_y <= o_left_b_y && o_point_y >= o_right_b_y)))
        else $error("curve point y outside second-level span");
`endif

endmodule

[verif/tb_cubic_bezier_eval_split.sv]
// self-checking testbench for the cubic bezier evaluator and splitter
`timescale 1ns / 100ps

module tb_cubic_bezier_eval_split;

    import cbz_pkg::*;

    localparam int COORD_W     = DEF_COORD_BITS;
    localparam int FRAC_W      = DEF_FRAC_BITS;
    localparam int SLOPE_W     = COORD_W + 3;
    localparam int IDX_W       = CFG_IDX_BITS;
    localparam int CFG_IDX_MAX = (1 << IDX_W) - 1;
    localparam int ONE_T       = 1 << FRAC_W;
    localparam int T_MAX       = (1 << (FRAC_W + 1)) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_TAIL  = 120;
    localparam int TAIL_CYCLES = 12;
    localparam int PRINT_MAX   = 40;

    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    typedef enum logic {WORD_PARAM, WORD_CFG} t_word_kind;
    typedef enum logic [1:0] {CURVE_RANDOM, CURVE_EXTREME, CURVE_SMALL, CURVE_FLAT} t_curve_kind;

    typedef struct {
        t_word_kind           kind;
        logic [FRAC_W:0]      param_t;
        logic [IDX_W-1:0]     idx;
        logic [COORD_W-1:0]   data;
    } t_feed_word;

    typedef struct {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [SLOPE_W-1:0] slope_x;
        logic signed [SLOPE_W-1:0] slope_y;
        logic signed [COORD_W-1:0] left_a_x;
        logic signed [COORD_W-1:0] left_a_y;
        logic signed [COORD_W-1:0] left_b_x;
        logic signed [COORD_W-1:0] left_b_y;
        logic signed [COORD_W-1:0] right_b_x;
        logic signed [COORD_W-1:0] right_b_y;
        logic signed [COORD_W-1:0] right_a_x;
        logic signed [COORD_W-1:0] right_a_y;
    } t_split_word;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // block inputs, known from time zero
    logic                i_cfg_we   = 1'b0;
    logic [IDX_W-1:0]    i_cfg_idx  = '0;
    logic [COORD_W-1:0]  i_cfg_data = '0;
    logic                start      = 1'b0;
    logic [FRAC_W:0]     i_param_t  = '0;

    // block outputs
    logic                      busy;
    logic                      o_valid;
    logic signed [COORD_W-1:0] o_point_x, o_point_y;
    logic signed [SLOPE_W-1:0] o_slope_x, o_slope_y;
    logic signed [COORD_W-1:0] o_left_a_x, o_left_a_y, o_left_b_x, o_left_b_y;
    logic signed [COORD_W-1:0] o_right_b_x, o_right_b_y, o_right_a_x, o_right_a_y;

    cubic_bezier_eval_split i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_param_t   (i_param_t),
        .o_valid     (o_valid),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_slope_x   (o_slope_x),
        .o_slope_y   (o_slope_y),
        .o_left_a_x  (o_left_a_x),
        .o_left_a_y  (o_left_a_y),
        .o_left_b_x  (o_left_b_x),
        .o_left_b_y  (o_left_b_y),
        .o_right_b_x (o_right_b_x),
        .o_right_b_y (o_right_b_y),
        .o_right_a_x (o_right_a_x),
        .o_right_a_y (o_right_a_y)
    );

    // testbench state
    t_feed_word         t_feed[$];
    t_split_word        awaited_splits[$];
    logic [COORD_W-1:0] coord_regs[NUM_REGS];
    logic               word_taken = 1'b0;
    int                 gap_left = 0;
    int                 cycle_cnt = 0;
    int                 mismatch_cnt = 0;
    int                 splits_checked = 0;
    int                 params_sent = 0;
    int                 clamped_params = 0;
    int                 reg_writes = 0;

    // driver scratch
    logic               drv_start;
    logic [FRAC_W:0]    drv_t;
    logic               drv_we;
    logic [IDX_W-1:0]   drv_idx;
    logic [COORD_W-1:0] drv_data;

    // rounded fixed-point interpolation, ties toward plus infinity
    function automatic longint lerp_round(longint a, longint b, longint t);
        longint prod;
        prod = (b - a) * t + (longint'(1) <<< (FRAC_W - 1));
        return a + (prod >>> FRAC_W);
    endfunction

    // de casteljau construction on the current control points
    function automatic t_split_word bezier_split(logic [FRAC_W:0] raw_t);
        longint      t;
        longint      pt[4][2];
        longint      q0[2], q1[2], q2[2], r0[2], r1[2], s0[2], sl[2];
        t_split_word w;
        t = (raw_t > ONE_T) ? longint'(ONE_T) : longint'(raw_t);
        for (int k = 0; k < 4; k++)
            for (int c = 0; c < 2; c++)
                pt[k][c] = longint'(signed'(coord_regs[2 * k + c]));
        for (int c = 0; c < 2; c++) begin
            q0[c] = lerp_round(pt[0][c], pt[1][c], t);
            q1[c] = lerp_round(pt[1][c], pt[2][c], t);
            q2[c] = lerp_round(pt[2][c], pt[3][c], t);
            r0[c] = lerp_round(q0[c], q1[c], t);
            r1[c] = lerp_round(q1[c], q2[c], t);
            s0[c] = lerp_round(r0[c], r1[c], t);
            sl[c] = 3 * (r1[c] - r0[c]);
        end
        w.point_x   = COORD_W'(s0[AX_X]);
        w.point_y   = COORD_W'(s0[AX_Y]);
        w.slope_x   = SLOPE_W'(sl[AX_X]);
        w.slope_y   = SLOPE_W'(sl[AX_Y]);
        w.left_a_x  = COORD_W'(q0[AX_X]);
        w.left_a_y  = COORD_W'(q0[AX_Y]);
        w.left_b_x  = COORD_W'(r0[AX_X]);
        w.left_b_y  = COORD_W'(r0[AX_Y]);
        w.right_b_x = COORD_W'(r1[AX_X]);
        w.right_b_y = COORD_W'(r1[AX_Y]);
        w.right_a_x = COORD_W'(q2[AX_X]);
        w.right_a_y = COORD_W'(q2[AX_Y]);
        return w;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_MAX)
            $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // stimulus helpers
    task automatic queue_param(int unsigned t);
        t_feed_word fw;
        fw.kind    = WORD_PARAM;
        fw.param_t = (FRAC_W + 1)'(t);
        fw.idx     = '0;
        fw.data    = '0;
        t_feed.push_back(fw);
    endtask

    task automatic queue_cfg(int idx, logic [COORD_W-1:0] data);
        t_feed_word fw;
        fw.kind    = WORD_CFG;
        fw.param_t = '0;
        fw.idx     = IDX_W'(idx);
        fw.data    = data;
        t_feed.push_back(fw);
    endtask

    task automatic queue_curve(t_curve_kind kind);
        logic [COORD_W-1:0] base[2];
        logic [COORD_W-1:0] v;
        base[AX_X] = COORD_W'($urandom);
        base[AX_Y] = COORD_W'($urandom);
        for (int r = 0; r < NUM_REGS; r++) begin
            case (kind)
                CURVE_EXTREME: v = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
                CURVE_SMALL:   v = COORD_W'($urandom_range(0, 16) - 8);
                CURVE_FLAT:    v = base[r % 2];
                default:       v = COORD_W'($urandom);
            endcase
            queue_cfg(r, v);
        end
    endtask

    function automatic int unsigned random_t();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0: begin
                case ($urandom_range(0, 5))
                    0: return 0;
                    1: return 1;
                    2: return ONE_T / 2 - 1;
                    3: return ONE_T / 2;
                    4: return ONE_T - 1;
                    default: return ONE_T;
                endcase
            end
            1, 2: return $urandom_range(ONE_T + 1, T_MAX);
            default: return $urandom_range(0, ONE_T);
        endcase
    endfunction

    // driver: one word per falling edge or a gap; config writes only if pipe empty
    always @(negedge i_clk) begin
        drv_start = start && !word_taken;
        drv_t     = i_param_t;
        drv_we    = 1'b0;
        drv_idx   = i_cfg_idx;
        drv_data  = i_cfg_data;
        if (i_rst_n && !drv_start) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (t_feed.size() > 0) begin
                if (t_feed[0].kind == WORD_PARAM) begin
                    drv_start = 1'b1;
                    drv_t     = t_feed[0].param_t;
                    void'(t_feed.pop_front());
                    if (t_feed.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 8);
                end else if (awaited_splits.size() == 0) begin
                    drv_we   = 1'b1;
                    drv_idx  = t_feed[0].idx;
                    drv_data = t_feed[0].data;
                    void'(t_feed.pop_front());
                end
            end
        end
        start      <= drv_start;
        i_param_t  <= drv_t;
        i_cfg_we   <= drv_we;
        i_cfg_idx  <= drv_idx;
        i_cfg_data <= drv_data;
    end

    // monitor: check results, predict accepted words, track register writes
    always @(posedge i_clk) begin
        t_split_word want;
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
            for (int r = 0; r < NUM_REGS; r++) coord_regs[r] = '0;
        end else begin
            if (o_valid) begin
                if (awaited_splits.size() == 0) begin
                    report_mismatch("result with no word outstanding");
                end else begin
                    want = awaited_splits.pop_front();
                    splits_checked++;
                    check_field("point_x",   o_point_x,   want.point_x);
                    check_field("point_y",   o_point_y,   want.point_y);
                    check_field("slope_x",   o_slope_x,   want.slope_x);
                    check_field("slope_y",   o_slope_y,   want.slope_y);
                    check_field("left_a_x",  o_left_a_x,  want.left_a_x);
                    check_field("left_a_y",  o_left_a_y,  want.left_a_y);
                    check_field("left_b_x",  o_left_b_x,  want.left_b_x);
                    check_field("left_b_y",  o_left_b_y,  want.left_b_y);
                    check_field("right_b_x", o_right_b_x, want.right_b_x);
                    check_field("right_b_y", o_right_b_y, want.right_b_y);
                    check_field("right_a_x", o_right_a_x, want.right_a_x);
                    check_field("right_a_y", o_right_a_y, want.right_a_y);
                end
            end
            if (start && !busy) begin
                awaited_splits.push_back(bezier_split(i_param_t));
                params_sent++;
                if (i_param_t > ONE_T) clamped_params++;
            end
            word_taken <= start && !busy;
            if (i_cfg_we) begin
                reg_writes++;
                if (i_cfg_idx < NUM_REGS)
                    coord_regs[i_cfg_idx[REG_SEL_BITS-1:0]] = i_cfg_data;
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("mismatch: run timed out after %0d cycles", cycle_cnt);
        $display("FAIL");
        $finish;
    end

    // stimulus and end of run
    initial begin
        // reset register values
        queue_param(0);
        queue_param(ONE_T);

        // extreme control points, steepest tangents
        queue_cfg(REG_P0_X, COORD_MIN);
        queue_cfg(REG_P0_Y, COORD_MAX);
        queue_cfg(REG_P1_X, COORD_MAX);
        queue_cfg(REG_P1_Y, COORD_MIN);
        queue_cfg(REG_P2_X, COORD_MIN);
        queue_cfg(REG_P2_Y, COORD_MAX);
        queue_cfg(REG_P3_X, COORD_MAX);
        queue_cfg(REG_P3_Y, COORD_MIN);
        queue_param(0);
        queue_param(1);
        queue_param(ONE_T / 4);
        queue_param(ONE_T / 2);
        queue_param(3 * ONE_T / 4);
        queue_param(ONE_T - 1);
        queue_param(ONE_T);
        // parameter above one is clamped
        queue_param(ONE_T + 1);
        queue_param(T_MAX);
        queue_param(17'h0AAAA);
        queue_param(17'h15555);

        // writes to indexes past the register file are dropped
        queue_cfg(NUM_REGS, 16'h5A5A);
        queue_cfg(CFG_IDX_MAX, 16'hFFFF);
        queue_param(ONE_T / 2);
        queue_param(ONE_T / 3);

        // odd differences at one half hit the rounding ties
        queue_cfg(REG_P0_X, 16'd0);
        queue_cfg(REG_P0_Y, 16'd0);
        queue_cfg(REG_P1_X, 16'd1);
        queue_cfg(REG_P1_Y, 16'hFFFF);
        queue_cfg(REG_P2_X, 16'd4);
        queue_cfg(REG_P2_Y, 16'hFFFB);
        queue_cfg(REG_P3_X, 16'hFFFF);
        queue_cfg(REG_P3_Y, 16'd2);
        queue_param(ONE_T / 2);
        queue_param(1);
        queue_param(ONE_T - 1);

        // random curves, one phase per set of control points
        for (int ph = 0; ph < 13; ph++) begin
            if (ph < 4) queue_curve(t_curve_kind'(ph));
            else        queue_curve(t_curve_kind'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0)
                queue_cfg(NUM_REGS + $urandom_range(0, CFG_IDX_MAX - NUM_REGS),
                          COORD_W'($urandom));
            repeat ($urandom_range(40, 72)) queue_param(random_t());
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (t_feed.size() != 0 || start) @(negedge i_clk);
        while (awaited_splits.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        while (awaited_splits.size() != 0) begin
            void'(awaited_splits.pop_front());
            report_mismatch("expected result never arrived");
        end

        $display("run covered %0d parameter words (%0d clamped above one), %0d register writes",
                 params_sent, clamped_params, reg_writes);
        $display("%0d results checked field by field, %0d mismatches",
                 splits_checked, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/cbz_pkg.sv
sv/cbz_lerp.sv
sv/cubic_bezier_eval_split.sv
verif/tb_cubic_bezier_eval_split.sv
